@@ hdl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the sync frame receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam logic [2:0] POS_HUNT  = 3'd0;
	localparam logic [2:0] POS_B1    = 3'd1;
	localparam logic [2:0] POS_B2    = 3'd2;
	localparam logic [2:0] POS_B3    = 3'd3;
	localparam logic [2:0] POS_CHECK = 3'd4;
	localparam logic [2:0] POS_LAST  = 3'd5;

	localparam logic [7:0] COUNT_MAX     = 8'hFF;
	localparam logic [7:0] START_RESET   = 8'h7E;
	localparam logic [7:0] TIMEOUT_RESET = 8'd10;

	localparam logic REG_START   = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] miss_count;
		logic [7:0] second_signal;
		logic [7:0] first_signal;
		logic       link_ok;
		logic       frame_good;
	} result_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] timeout_ticks;
	} cfg_t;

endpackage

@@ hdl/sync_frame_receiver_with_timeout_core.sv @@
// ----------------------------------------------------------------------------
// sync_frame_receiver_with_timeout_core
// Start-byte framed six-byte receiver with checksum and tick-based link timeout.
//
//   channel   direction  tdata (low bit up)                         tuser
//   s_axis    in         rx_byte[7:0]                               req_type
//   m_axis    out        frame_good, link_ok, first_signal,         -
//                        second_signal, miss_count, 6'b0 pad
//   cfg       in         index 0 start_byte, 1 timeout_ticks        -
//
// One word per cycle while the sink does not stall: the input register takes the
// word, and the result register takes its update once it can be refilled.
// Reset clears frame position, held bytes, latched signals, link and count.
// A stalled sink holds the result register; input is still taken while the
// result register can be refilled in the same cycle.
// ----------------------------------------------------------------------------
module sync_frame_receiver_with_timeout_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // frame_good, link_ok, first_signal,
	                                    // second_signal, miss_count, zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import sfr_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    can_load;
	logic    step;
	cfg_t    cfg_q;
	result_t result;
	result_t out_result;

	assign in_item.req_type = s_axis_tuser;
	assign in_item.rx_byte  = s_axis_tdata;
	assign step             = valid_s1 && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= START_RESET;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START:   cfg_q.start_byte    <= cfg_data;
				REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				default:     cfg_q               <= cfg_q;
			endcase
		end
	end

	sfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (can_load),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sfr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	sfr_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s1),
		.result     (result),
		.can_load   (can_load),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result)
	);

	assign m_axis_tdata = {6'd0, out_result};

endmodule

@@ hdl/sfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// sfr_in_stage
// Input register: holds one accepted word until the update stage takes it.
// ----------------------------------------------------------------------------
module sfr_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sfr_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output sfr_pkg::item_t item_s1
);
	import sfr_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ hdl/sfr_core.sv @@
// ----------------------------------------------------------------------------
// sfr_core
// Frame state, checksum test and tick counter; updated once per word.
// ----------------------------------------------------------------------------
module sfr_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  sfr_pkg::item_t   item,
	input  sfr_pkg::cfg_t    cfg,
	output sfr_pkg::result_t result
);
	import sfr_pkg::*;

	logic [2:0] pos_q, pos_n;
	logic [7:0] sum_q, sum_n;
	logic [7:0] first_q, first_n;
	logic [7:0] second_q, second_n;
	logic [7:0] check_q, check_n;
	logic [7:0] lat_first_q, lat_first_n;
	logic [7:0] lat_second_q, lat_second_n;
	logic       link_q, link_n;
	logic [7:0] ticks_q, ticks_n;
	logic       good;
	logic       chk_match;

	assign chk_match = ({1'b0, ~sum_q[6:0]} == check_q);

	always_comb begin
		pos_n        = pos_q;
		sum_n        = sum_q;
		first_n      = first_q;
		second_n     = second_q;
		check_n      = check_q;
		lat_first_n  = lat_first_q;
		lat_second_n = lat_second_q;
		link_n       = link_q;
		ticks_n      = ticks_q;
		good         = 1'b0;
		if (item.req_type == KIND_TICK) begin
			if (ticks_q != COUNT_MAX) begin
				ticks_n = ticks_q + 8'd1;
			end
			if (ticks_n > cfg.timeout_ticks) begin
				link_n = 1'b0;
			end
		end else begin
			case (pos_q)
				POS_HUNT: begin
					if (item.rx_byte == cfg.start_byte) begin
						pos_n = POS_B1;
					end
				end
				POS_B1: begin
					first_n = item.rx_byte;
					sum_n   = item.rx_byte;
					pos_n   = POS_B2;
				end
				POS_B2: begin
					second_n = item.rx_byte;
					sum_n    = sum_q + item.rx_byte;
					pos_n    = POS_B3;
				end
				POS_B3: begin
					sum_n = sum_q + item.rx_byte;
					pos_n = POS_CHECK;
				end
				POS_CHECK: begin
					check_n = item.rx_byte;
					pos_n   = POS_LAST;
				end
				POS_LAST: begin
					if (chk_match) begin
						lat_first_n  = first_q;
						lat_second_n = second_q;
						link_n       = 1'b1;
						ticks_n      = 8'd0;
						good         = 1'b1;
					end
					pos_n = POS_HUNT;
				end
				default: begin
					pos_n = POS_HUNT;
				end
			endcase
		end
	end

	assign result.frame_good    = good;
	assign result.link_ok       = link_n;
	assign result.first_signal  = lat_first_n;
	assign result.second_signal = lat_second_n;
	assign result.miss_count    = ticks_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_HUNT;
			sum_q        <= 8'd0;
			first_q      <= 8'd0;
			second_q     <= 8'd0;
			check_q      <= 8'd0;
			lat_first_q  <= 8'd0;
			lat_second_q <= 8'd0;
			link_q       <= 1'b0;
			ticks_q      <= 8'd0;
		end else if (step) begin
			pos_q        <= pos_n;
			sum_q        <= sum_n;
			first_q      <= first_n;
			second_q     <= second_n;
			check_q      <= check_n;
			lat_first_q  <= lat_first_n;
			lat_second_q <= lat_second_n;
			link_q       <= link_n;
			ticks_q      <= ticks_n;
		end
	end

`ifndef SYNTH
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 3'd6 && pos_q != 3'd7)
		else $error("frame position out of range");

	a_good_clears_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		step && good |=> ticks_q == 8'd0 && link_q)
		else $error("good frame did not clear tick count and raise link");

	a_link_rise: assert property (@(posedge clk) disable iff (!arst_n)
		step && !link_q && link_n |-> good && pos_q == POS_LAST)
		else $error("link raised without a good frame");

	a_tick_hold_frame: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.req_type == KIND_TICK |=> $stable(pos_q) && $stable(sum_q))
		else $error("tick disturbed frame state");
`endif

endmodule

@@ hdl/sfr_out_stage.sv @@
// ----------------------------------------------------------------------------
// sfr_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module sfr_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sfr_pkg::result_t result,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output sfr_pkg::result_t out_result
);
	import sfr_pkg::*;

	logic    valid_q;
	result_t result_q;

	assign can_load   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			result_q <= result;
		end
	end

endmodule
